### hw/rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 ECB package
// Shared types, constants, S-box tables and round functions.
// ----------------------------------------------------------------------------
package aes_pkg;

  typedef logic [127:0] blk_t;
  typedef logic [4:0]   nbytes_t;
  typedef logic [3:0]   rk_idx_t;

  // Index of the last round and of the last round key.
  localparam rk_idx_t LAST_ROUND = 4'd10;
  localparam int      NUM_RK     = 11;

  // Configuration address width and register indexes (64-bit registers).
  localparam int         CFG_AW       = 5;
  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_DIR      = 2'd2;

  // One queued block between the front and the back.
  typedef struct packed {
    blk_t    data;
    nbytes_t nbytes;
    logic    full;
  } aes_item_t;

  // Forward S-box, byte 0 in the top bits.
  localparam logic [2047:0] SBOX_BITS = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  // Inverse S-box, built at elaboration from the forward table.
  function automatic logic [2047:0] build_inv();
    logic [2047:0] t;
    int            idx;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      idx = int'(SBOX_BITS[2047 - 8*i -: 8]);
      t[2047 - 8*idx -: 8] = 8'(i);
    end
    return t;
  endfunction

  localparam logic [2047:0] INV_BITS = build_inv();

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX_BITS[11'd2047 - {b, 3'b000} -: 8];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] b);
    return INV_BITS[11'd2047 - {b, 3'b000} -: 8];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Forward column mix on one 32-bit column, top byte first.
  function automatic logic [31:0] mix_fwd(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
            xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  // Inverse column mix with factors 14, 11, 13 and 9.
  function automatic logic [31:0] mix_inv(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] m9 [4], m11 [4], m13 [4], m14 [4];
    logic [7:0] x2, x4, x8;
    a[0] = w[31:24]; a[1] = w[23:16]; a[2] = w[15:8]; a[3] = w[7:0];
    for (int k = 0; k < 4; k++) begin
      x2 = xt(a[k]);
      x4 = xt(x2);
      x8 = xt(x4);
      m9[k]  = x8 ^ a[k];
      m11[k] = x8 ^ x2 ^ a[k];
      m13[k] = x8 ^ x4 ^ a[k];
      m14[k] = x8 ^ x4 ^ x2;
    end
    return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
            m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
            m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
            m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
  endfunction

  // One forward round; the last round skips the column mix.
  function automatic blk_t enc_round(input blk_t s, input blk_t rk, input logic last);
    blk_t sb, sh, mx;
    for (int i = 0; i < 16; i++) sb[127 - 8*i -: 8] = sbox(s[127 - 8*i -: 8]);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        sh[127 - 8*(r + 4*c) -: 8] = sb[127 - 8*(r + 4*((c + r) & 3)) -: 8];
      end
    end
    for (int c = 0; c < 4; c++) mx[127 - 32*c -: 32] = mix_fwd(sh[127 - 32*c -: 32]);
    return (last ? sh : mx) ^ rk;
  endfunction

  // One inverse round; the last round skips the inverse column mix.
  function automatic blk_t dec_round(input blk_t s, input blk_t rk, input logic last);
    blk_t sh, sb, ak, mx;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        sh[127 - 8*(r + 4*((c + r) & 3)) -: 8] = s[127 - 8*(r + 4*c) -: 8];
      end
    end
    for (int i = 0; i < 16; i++) sb[127 - 8*i -: 8] = inv_sbox(sh[127 - 8*i -: 8]);
    ak = sb ^ rk;
    for (int c = 0; c < 4; c++) mx[127 - 32*c -: 32] = mix_inv(ak[127 - 32*c -: 32]);
    return last ? ak : mx;
  endfunction

  // Next round key from the previous one.
  function automatic blk_t next_rk(input blk_t p, input logic [7:0] rcon);
    logic [31:0] t, n0, n1, n2, n3;
    t  = {sbox(p[23:16]) ^ rcon, sbox(p[15:8]), sbox(p[7:0]), sbox(p[31:24])};
    n0 = p[127:96] ^ t;
    n1 = p[95:64] ^ n0;
    n2 = p[63:32] ^ n1;
    n3 = p[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

### hw/rtl/aes_if.sv
// ----------------------------------------------------------------------------
// AES-128 ECB stream interfaces
// Valid/ready channels for input blocks and result blocks.
// ----------------------------------------------------------------------------
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic [4:0]  valid_bytes;

  modport source (output valid, block_high, block_low, valid_bytes, input ready);
  modport sink   (input valid, block_high, block_low, valid_bytes, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  logic [4:0]  result_bytes;

  modport source (output valid, result_high, result_low, result_bytes, input ready);
  modport sink   (input valid, result_high, result_low, result_bytes, output ready);
endinterface

### hw/rtl/aes_key_sched.sv
// ----------------------------------------------------------------------------
// AES-128 key schedule and configuration registers
// APB register file; expands eleven round keys, one per cycle.
// ----------------------------------------------------------------------------
module aes_key_sched import aes_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  input  rk_idx_t           rk_idx,
  output blk_t              rk,
  output logic              key_busy,
  output logic              dir
);

  typedef enum logic [2:0] {
    KS_LOAD = 3'b001,
    KS_EXP  = 3'b010,
    KS_DONE = 3'b100
  } ks_state_t;

  ks_state_t   state_r, state_nxt;
  logic [63:0] key_hi_r, key_lo_r;
  logic        dir_r;
  rk_idx_t     cnt_r;
  logic [7:0]  rcon_r;
  blk_t        cur_r, rk_new;
  blk_t        rk_mem [NUM_RK];
  logic        wr_en, key_wr;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:3];
  assign wr_en   = psel && penable && pwrite;
  assign key_wr  = wr_en && (reg_idx == REG_KEY_HIGH || reg_idx == REG_KEY_LOW);

  // Register read back.
  always_comb begin
    case (reg_idx)
      REG_KEY_HIGH: prdata = key_hi_r;
      REG_KEY_LOW:  prdata = key_lo_r;
      REG_DIR:      prdata = {63'd0, dir_r};
      default:      prdata = '0;
    endcase
  end

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      dir_r    <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_KEY_HIGH: key_hi_r <= pwdata;
        REG_KEY_LOW:  key_lo_r <= pwdata;
        REG_DIR:      dir_r    <= pwdata[0];
        default:      ;
      endcase
    end
  end

  // Expansion sequencer: load the key, then ten expansion steps; a key register write restarts it.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      KS_LOAD: state_nxt = KS_EXP;
      KS_EXP:  if (cnt_r == LAST_ROUND) state_nxt = KS_DONE;
      KS_DONE: state_nxt = KS_DONE;
      default: state_nxt = KS_LOAD;
    endcase
    if (key_wr) state_nxt = KS_LOAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KS_LOAD;
      cnt_r   <= 4'd1;
      rcon_r  <= 8'h01;
    end else begin
      state_r <= state_nxt;
      if (state_r == KS_LOAD) begin
        cnt_r  <= 4'd1;
        rcon_r <= 8'h01;
      end else if (state_r == KS_EXP) begin
        cnt_r  <= cnt_r + 4'd1;
        rcon_r <= xt(rcon_r);
      end
    end
  end

  assign rk_new = next_rk(cur_r, rcon_r);

  // Round key store.
  always_ff @(posedge clk) begin
    if (state_r == KS_LOAD) begin
      rk_mem[0] <= {key_hi_r, key_lo_r};
      cur_r     <= {key_hi_r, key_lo_r};
    end else if (state_r == KS_EXP) begin
      rk_mem[cnt_r] <= rk_new;
      cur_r         <= rk_new;
    end
  end

  assign rk       = rk_mem[rk_idx];
  assign key_busy = (state_r != KS_DONE);
  assign dir      = dir_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == KS_EXP) |-> (cnt_r >= 4'd1 && cnt_r <= LAST_ROUND))
    else $error("key expansion step out of range");

endmodule

### hw/rtl/aes_front.sv
// ----------------------------------------------------------------------------
// AES-128 ECB front end
// Accepts blocks, masks short blocks and queues them for the round engine.
// ----------------------------------------------------------------------------
module aes_front import aes_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  aes_in_if.sink    in_ch,
  input  logic      key_busy,
  output aes_item_t q_item,
  output logic      q_valid,
  input  logic      q_pop
);

  aes_item_t  q_mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  blk_t       raw, mask;
  aes_item_t  item_in;

  // Keep the leading bytes that are present; the rest become zero.
  always_comb begin
    raw = {in_ch.block_high, in_ch.block_low};
    for (int i = 0; i < 16; i++) begin
      mask[127 - 8*i -: 8] = (5'(i) < in_ch.valid_bytes) ? 8'hff : 8'h00;
    end
    item_in.data   = raw & mask;
    item_in.nbytes = in_ch.valid_bytes;
    item_in.full   = in_ch.valid_bytes[4];
  end

  assign in_ch.ready = !key_busy && (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;

  // Two-entry queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push)  wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr_r] <= item_in;
  end

  assign q_item  = q_mem[rd_ptr_r];
  assign q_valid = (cnt_r != 2'd0);

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_key_stall: assert property (@(posedge clk) disable iff (!rst_n)
    key_busy |-> !push)
    else $error("transaction accepted during key expansion");

endmodule

### hw/rtl/aes_back.sv
// ----------------------------------------------------------------------------
// AES-128 ECB round engine and output register; short blocks skip the rounds
// Runs one round per cycle; the last one waits for a free output register.
// ----------------------------------------------------------------------------
module aes_back import aes_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  aes_item_t q_item,
  input  logic      q_valid,
  output logic      q_pop,
  input  logic      dir,
  output rk_idx_t   rk_idx,
  input  blk_t      rk,
  aes_out_if.source out_ch
);

  logic    busy_r, out_valid_r;
  rk_idx_t rnd_r, rnd_sel;
  blk_t    st_r, out_data_r, round_out;
  nbytes_t nb_r, out_nb_r;
  logic    out_free, last, finish;

  assign out_free = !out_valid_r || out_ch.ready;
  assign last     = (rnd_r == LAST_ROUND);
  assign finish   = busy_r && last && out_free;
  assign q_pop    = q_valid && !busy_r && (q_item.full || out_free);

  // Round key select: the decrypt schedule runs backwards.
  assign rnd_sel = busy_r ? rnd_r : 4'd0;
  assign rk_idx  = dir ? (LAST_ROUND - rnd_sel) : rnd_sel;

  assign round_out = dir ? dec_round(st_r, rk, last) : enc_round(st_r, rk, last);

  // Round iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= 4'd0;
    end else if (q_pop && q_item.full) begin
      busy_r <= 1'b1;
      rnd_r  <= 4'd1;
    end else if (busy_r && !last) begin
      rnd_r <= rnd_r + 4'd1;
    end else if (finish) begin
      busy_r <= 1'b0;
      rnd_r  <= 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.full) begin
      st_r <= q_item.data ^ rk;
      nb_r <= q_item.nbytes;
    end else if (busy_r && !last) begin
      st_r <= round_out;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish || (q_pop && !q_item.full)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= round_out;
      out_nb_r   <= nb_r;
    end else if (q_pop && !q_item.full) begin
      out_data_r <= q_item.data;
      out_nb_r   <= q_item.nbytes;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_high  = out_data_r[127:64];
  assign out_ch.result_low   = out_data_r[63:0];
  assign out_ch.result_bytes = out_nb_r;

  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rnd_r >= 4'd1 && rnd_r <= LAST_ROUND))
    else $error("round counter out of range");
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> (!busy_r && out_valid_r))
    else $error("finished block not presented");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !q_pop)
    else $error("queue popped while engine busy");

endmodule

### hw/rtl/aes128_ecb_block_cipher_unit.sv
// Full block: initial key add as it leaves the queue, then ten rounds in the round
// engine, one round per cycle, the last waiting for a free output register; no block
// leaves the queue meanwhile. Short blocks go straight to the output register.
// After reset, or after a key register write, the key schedule expands eleven round
// keys, one per cycle, and no input transaction is accepted meanwhile.
// Reset is synchronous, active low; the key registers and direction reset to zero.
// ----------------------------------------------------------------------------
// AES-128 ECB block cipher unit
// Top level: front queue, round engine and APB-configured key schedule.
// ----------------------------------------------------------------------------
module aes128_ecb_block_cipher_unit import aes_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  aes_in_if.sink            in_ch,
  aes_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  aes_item_t q_item;
  logic      q_valid, q_pop, key_busy, dir;
  rk_idx_t   rk_idx;
  blk_t      rk;

  aes_key_sched u_key (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .rk_idx, .rk, .key_busy, .dir
  );

  aes_front u_front (
    .clk, .rst_n, .in_ch, .key_busy, .q_item, .q_valid, .q_pop
  );

  aes_back u_back (
    .clk, .rst_n, .q_item, .q_valid, .q_pop, .dir, .rk_idx, .rk, .out_ch
  );

endmodule
